// File: rtl/page_bitmap_allocator_top_defines.svh
// assertion macros for the page bitmap allocator checker
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pba check failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pba check failed");

`endif

// File: rtl/pba_pkg.sv
// types and constants of the page bitmap allocator
`default_nettype none
package pba_pkg;
    localparam logic [1:0] OP_MARK    = 2'd0;
    localparam logic [1:0] OP_ALLOC1  = 2'd1;
    localparam logic [1:0] OP_ALLOC8  = 2'd2;
    localparam logic [1:0] OP_ALLOC32 = 2'd3;

    localparam logic [3:0] TYPE_AVAIL = 4'd1;
    localparam logic [3:0] TYPE_RECL  = 4'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] region_addr;
        logic [31:0] region_len;
        logic [3:0]  region_type;
    } t_in;

    typedef struct packed {
        logic        granted;
        logic [14:0] page_index;
    } t_out;
endpackage
`default_nettype wire

// File: rtl/page_bitmap_allocator_top.sv
// page bitmap allocator: used-page map in a word memory with a next-fit hint
//
// input channel i_in_valid / o_in_ready carries one command (mark a region,
// allocate one page, eight pages or an aligned 32-page word); the output
// channel o_out_valid / i_out_ready returns one result per command.
// the map is a memory of NUM_PAGES/32 words with a registered read; each word
// visited takes a read step, then an evaluate and write-back step.
// mark: a setup step, then a visit to each map word the region touches.
// allocation: words are scanned one by one from the hint word until one has
// room or the scan has wrapped around the whole map.
// after reset the block runs a clearing pass over all NUM_PAGES/32 words that
// zeroes the map; o_in_ready stays low until it ends.
// one result register sits at the output: a new command is taken while a
// result waits; a finished command holds until that register is free.
// the bit of page p is bit p%32 of word p/32.
`default_nettype none
module page_bitmap_allocator_top #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  pba_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output pba_pkg::t_out  o_out_data
);
    import pba_pkg::*;

    localparam int MAP_WORDS = NUM_PAGES / 32;
    localparam int WA = $clog2(MAP_WORDS);
    localparam int PW = WA + 5;
    localparam int CW = $clog2(MAP_WORDS + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MSET = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EV   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [31:0] r_mem [MAP_WORDS];
    logic [31:0] r_q;
    logic        mem_we;
    logic [31:0] mem_wd;

    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic [3:0]    r_type;
    logic [32:0]   r_end;
    logic [32:0]   r_alig;
    logic [PW-1:0] r_first;
    logic [PW-1:0] r_last;
    logic [PW-1:0] r_hint;
    logic [WA-1:0] r_wa;
    logic [CW-1:0] r_cnt;
    logic          r_res_g;
    logic [PW-1:0] r_res_p;
    logic          r_out_valid;
    t_out          r_out;

    logic [32:0]   m_first;
    logic [32:0]   m_last;
    logic          m_skip;
    logic [4:0]    lo_b;
    logic [4:0]    hi_b;
    logic [31:0]   mark_mask;
    logic [3:0]    allow;
    logic [3:0]    cand;
    logic [1:0]    k_sel;
    logic          byte_hit;
    logic [7:0]    sel_byte;
    logic [2:0]    j_sel;
    logic          hit;
    logic [4:0]    hit_off;
    logic [31:0]   alloc_word;
    logic          last_word;
    logic [WA-1:0] wa_next;
    logic [31:0]   res_page32;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign wa_next     = (r_wa == WA'(MAP_WORDS - 1)) ? '0 : r_wa + 1'b1;
    assign res_page32  = 32'(r_res_p);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wa] <= mem_wd;
        end
        r_q <= r_mem[r_wa];
    end

    always_comb begin
        m_first = r_alig >> PAGE_SHIFT;
        m_last  = (r_end - 33'd1) >> PAGE_SHIFT;
        if (m_last > 33'(NUM_PAGES - 1)) begin
            m_last = 33'(NUM_PAGES - 1);
        end
        m_skip = (r_type == TYPE_AVAIL) || (r_type == TYPE_RECL) ||
                 (r_alig >= r_end) || (m_first > m_last);
    end

    always_comb begin
        lo_b = (r_wa == r_first[PW-1:5]) ? r_first[4:0] : 5'd0;
        hi_b = (r_wa == r_last[PW-1:5]) ? r_last[4:0] : 5'd31;
        mark_mask = (32'hffffffff << lo_b) & (32'hffffffff >> (5'd31 - hi_b));
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_cnt == '0) begin
                allow[k] = (2'(k) >= r_hint[4:3]);
            end else if (r_cnt == CW'(MAP_WORDS)) begin
                allow[k] = (2'(k) < r_hint[4:3]);
            end else begin
                allow[k] = 1'b1;
            end
            if (r_op == OP_ALLOC1) begin
                cand[k] = allow[k] && (r_q[8*k +: 8] != 8'hff);
            end else begin
                cand[k] = allow[k] && (r_q[8*k +: 8] == 8'h00);
            end
        end
        k_sel = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (cand[k]) begin
                k_sel = 2'(k);
            end
        end
        byte_hit = |cand;
        sel_byte = r_q[8*k_sel +: 8];
        j_sel = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!sel_byte[j]) begin
                j_sel = 3'(j);
            end
        end
        case (r_op)
            OP_ALLOC1: begin
                hit        = byte_hit;
                hit_off    = {k_sel, j_sel};
                alloc_word = r_q | (32'd1 << {k_sel, j_sel});
            end
            OP_ALLOC8: begin
                hit        = byte_hit;
                hit_off    = {k_sel, 3'd0};
                alloc_word = r_q | (32'hff << {k_sel, 3'd0});
            end
            default: begin
                hit        = (r_q == 32'd0);
                hit_off    = 5'd0;
                alloc_word = 32'hffffffff;
            end
        endcase
        if (r_op == OP_ALLOC32) begin
            last_word = (r_cnt == CW'(MAP_WORDS - 1));
        end else begin
            last_word = (r_cnt == CW'(MAP_WORDS));
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wd = 32'd0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_EV: begin
                if (r_op == OP_MARK) begin
                    mem_we = 1'b1;
                    mem_wd = r_q | mark_mask;
                end else if (hit) begin
                    mem_we = 1'b1;
                    mem_wd = alloc_word;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_wa        <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_wa <= wa_next;
                    if (r_wa == WA'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.opcode;
                        r_type  <= i_in_data.region_type;
                        r_end   <= {1'b0, i_in_data.region_addr} +
                                   {1'b0, i_in_data.region_len};
                        r_alig  <= {1'b0, i_in_data.region_addr} &
                                   ~((33'd1 << PAGE_SHIFT) - 33'd1);
                        r_res_g <= 1'b0;
                        r_res_p <= '0;
                        r_cnt   <= '0;
                        r_wa    <= r_hint[PW-1:5];
                        if (i_in_data.opcode == OP_MARK) begin
                            r_state <= S_MSET;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_MSET: begin
                    r_first <= m_first[PW-1:0];
                    r_last  <= m_last[PW-1:0];
                    r_wa    <= m_first[PW-1:5];
                    r_state <= m_skip ? S_FIN : S_RD;
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (r_op == OP_MARK) begin
                        if (r_wa == r_last[PW-1:5]) begin
                            r_state <= S_FIN;
                        end else begin
                            r_wa    <= wa_next;
                            r_state <= S_RD;
                        end
                    end else if (hit) begin
                        r_res_g <= 1'b1;
                        r_res_p <= {r_wa, hit_off};
                        r_hint  <= {r_wa, hit_off};
                        r_state <= S_FIN;
                    end else if (last_word) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_wa    <= wa_next;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_out_valid || i_out_ready)) begin
            r_out.granted    <= r_res_g;
            r_out.page_index <= res_page32[14:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/pba_checker.sv
// port-level checks of the page bitmap allocator and their bind
`default_nettype none
`include "page_bitmap_allocator_top_defines.svh"
module pba_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_ready,
    input pba_pkg::t_in   i_in_data,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input pba_pkg::t_out  o_out_data
);
    import pba_pkg::*;

    `PBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `PBA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    `PBA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.granted, o_out_data.page_index == 15'd0)
    `PBA_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (.*);
`default_nettype wire

// File: tb/tb_page_bitmap_allocator_top.sv
// testbench for the page bitmap allocator: directed and random commands checked against a predictor
`timescale 1ns / 1ps
module tb_page_bitmap_allocator_top;
    import pba_pkg::*;

    localparam int NUM_PAGES = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int MAP_WORDS = NUM_PAGES / 32;
    localparam int MAP_BYTES = MAP_WORDS * 4;
    localparam int STALL_LIMIT = 40000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    logic [31:0] used_map [MAP_WORDS];
    logic [31:0] grant_hint;
    t_out expected_results [$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int transfer_count;
    int grant_count;
    int deny_count;
    int quiet_cycles;

    page_bitmap_allocator_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] map_byte(int k);
        return used_map[k >> 2][(k & 3) * 8 +: 8];
    endfunction

    function automatic void mark_pages(logic [31:0] addr, logic [31:0] len, logic [3:0] rtype);
        logic [63:0] end_addr;
        logic [63:0] first;
        logic [63:0] last;
        if (rtype == TYPE_AVAIL || rtype == TYPE_RECL) return;
        end_addr = {32'd0, addr} + {32'd0, len};
        first = {32'd0, addr} >> PAGE_SHIFT;
        if ((first << PAGE_SHIFT) >= end_addr) return;
        last = (end_addr - 64'd1) >> PAGE_SHIFT;
        if (last >= NUM_PAGES) last = 64'(NUM_PAGES - 1);
        for (longint p = first; p <= last; p++)
            used_map[p >> 5][p & 31] = 1'b1;
    endfunction

    function automatic bit alloc_bytes(bit whole, output logic [31:0] page);
        int start;
        int k;
        int j;
        logic [7:0] b;
        start = (grant_hint / 8) % MAP_BYTES;
        page = 0;
        for (int n = 0; n < MAP_BYTES; n++) begin
            k = (start + n) % MAP_BYTES;
            b = map_byte(k);
            if (whole && b == 8'h00) begin
                used_map[k >> 2][(k & 3) * 8 +: 8] = 8'hff;
                page = 8 * k;
                grant_hint = page;
                return 1'b1;
            end
            if (!whole && b != 8'hff) begin
                j = 0;
                while (b[j]) j++;
                used_map[k >> 2][(k & 3) * 8 + j] = 1'b1;
                page = 8 * k + j;
                grant_hint = page;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit alloc_word(output logic [31:0] page);
        int start;
        int w;
        start = (grant_hint / 32) % MAP_WORDS;
        page = 0;
        for (int n = 0; n < MAP_WORDS; n++) begin
            w = (start + n) % MAP_WORDS;
            if (used_map[w] == 32'd0) begin
                used_map[w] = 32'hffffffff;
                page = 32 * w;
                grant_hint = page;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out allocator_result(t_in cmd);
        t_out r;
        logic [31:0] page;
        bit ok;
        ok = 1'b0;
        page = 0;
        case (cmd.opcode)
            OP_MARK: mark_pages(cmd.region_addr, cmd.region_len, cmd.region_type);
            OP_ALLOC1: ok = alloc_bytes(1'b0, page);
            OP_ALLOC8: ok = alloc_bytes(1'b1, page);
            default: ok = alloc_word(page);
        endcase
        r.granted = ok;
        r.page_index = ok ? page[14:0] : 15'd0;
        return r;
    endfunction

    task automatic send_command(t_in cmd);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(allocator_result(cmd));
        transfer_count++;
    endtask

    function automatic t_in make_cmd(logic [1:0] op, logic [31:0] addr, logic [31:0] len,
                                     logic [3:0] rtype);
        t_in c;
        c.opcode = op;
        c.region_addr = addr;
        c.region_len = len;
        c.region_type = rtype;
        return c;
    endfunction

    function automatic t_in random_cmd();
        t_in c;
        int sel;
        c = make_cmd(2'($urandom_range(3)), $urandom, $urandom, 4'($urandom_range(15)));
        sel = $urandom_range(99);
        if (c.opcode == OP_MARK && sel < 70) begin
            c.region_addr = $urandom_range(0, 32'h07ff_ffff);
            c.region_len = $urandom_range(0, 32'h6000);
            if (sel < 10) c.region_addr[11:0] = 12'd0;
        end else if (c.opcode == OP_MARK && c.region_addr < 32'h0800_0000) begin
            c.region_type = sel[0] ? TYPE_AVAIL : TYPE_RECL;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result granted=%0d page=%0d", $time,
                         o_out_data.granted, o_out_data.page_index);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.granted) grant_count++; else deny_count++;
                if (o_out_data.granted !== exp_r.granted) begin
                    $display("%0t: granted expected %0d actual %0d", $time,
                             exp_r.granted, o_out_data.granted);
                    error_count++;
                end
                if (o_out_data.page_index !== exp_r.page_index) begin
                    $display("%0t: page_index expected %0d actual %0d", $time,
                             exp_r.page_index, o_out_data.page_index);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("tb_page_bitmap_allocator_top NOT OK");
                $finish;
            end
        end
    end

    task automatic test_mark_regions();
        send_command(make_cmd(OP_MARK, 32'h0000_0000, 32'h0000_1000, 4'd2));
        send_command(make_cmd(OP_MARK, 32'h0000_1800, 32'h0000_0000, 4'd2));
        send_command(make_cmd(OP_MARK, 32'h0000_4000, 32'h0000_0000, 4'd4));
        send_command(make_cmd(OP_MARK, 32'h0001_0000, 32'h0010_0000, TYPE_AVAIL));
        send_command(make_cmd(OP_MARK, 32'h0001_0000, 32'h0010_0000, TYPE_RECL));
        send_command(make_cmd(OP_MARK, 32'h0000_5123, 32'h0000_2000, 4'd15));
        send_command(make_cmd(OP_MARK, 32'hffff_f000, 32'hffff_ffff, 4'd0));
        send_command(make_cmd(OP_MARK, 32'h07ff_f000, 32'h0000_2000, 4'd2));
        send_command(make_cmd(OP_MARK, 32'h0000_8000, 32'h0000_7001, 4'd5));
    endtask

    task automatic test_allocations();
        send_command(make_cmd(OP_ALLOC1, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC1, 32'hffff_ffff, 32'hffff_ffff, 4'hf));
        send_command(make_cmd(OP_ALLOC8, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC32, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC1, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC8, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC32, 32'd0, 32'd0, 4'd0));
    endtask

    task automatic test_random(int count, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) send_command(random_cmd());
    endtask

    task automatic test_full_map();
        idle_pct = 0;
        stall_pct = 0;
        send_command(make_cmd(OP_MARK, 32'd0, 32'h0800_0000, 4'd2));
        send_command(make_cmd(OP_ALLOC1, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC8, 32'd0, 32'd0, 4'd0));
        send_command(make_cmd(OP_ALLOC32, 32'd0, 32'd0, 4'd0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        transfer_count = 0;
        grant_count = 0;
        deny_count = 0;
        quiet_cycles = 0;
        grant_hint = 0;
        foreach (used_map[i]) used_map[i] = 32'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_mark_regions();
        test_allocations();
        test_random(480, 0, 0);
        test_random(480, 60, 0);
        test_random(480, 0, 60);
        test_random(480, 8, 8);
        test_full_map();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);

        $display("commands sent: %0d (marks, single, byte and word allocations)", transfer_count);
        $display("results checked: %0d granted, %0d denied or mark", grant_count, deny_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_page_bitmap_allocator_top OK");
        end else begin
            $display("tb_page_bitmap_allocator_top NOT OK");
        end
        $finish;
    end
endmodule
